[rtl/lcm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the linked chain manager.
// No dependencies; every other file in rtl/ imports this package.
package lcm_pkg;

  localparam int unsigned ITEM_W = 7;
  localparam int unsigned CMD_W  = 2;

  // Command codes carried on the input channel
  typedef enum logic [CMD_W-1:0] {
    CMD_LINK   = 2'd0,
    CMD_UNLINK = 2'd1,
    CMD_QUERY  = 2'd2
  } lcm_cmd_e;

  // Datapath operation selected by the controller each cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_BACK,
    OP_COUNT,
    OP_EMIT
  } lcm_op_e;

  // Status from datapath to controller
  typedef struct packed {
    logic query_go;
    logic back_more;
    logic fwd_more;
    logic out_free;
    logic emit_last;
  } lcm_stat_t;

endpackage

[rtl/lcm_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command beats and result beats.
// Depends on lcm_pkg for field widths.
interface lcm_in_if;
  import lcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ITEM_W-1:0] item_a;
  logic [ITEM_W-1:0] item_b;

  modport source (output valid, output cmd, output item_a, output item_b, input ready);
  modport sink   (input valid, input cmd, input item_a, input item_b, output ready);
endinterface

interface lcm_out_if;
  import lcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [ITEM_W-1:0] member;
  logic [ITEM_W-1:0] chain_length;
  logic              last;

  modport source (output valid, output member, output chain_length, output last, input ready);
  modport sink   (input valid, input member, input chain_length, input last, output ready);
endinterface

[rtl/linked_chain_manager_unit.sv]
`timescale 1ns / 1ps
// Top level of the linked chain manager: controller plus datapath.
// Depends on lcm_pkg, lcm_if, lcm_controller and lcm_datapath.
//
// Keeps predecessor and successor links over items 1..CARS (0 means no link),
// both cleared by reset. Link and unlink beats give no result; a beat with an
// item out of range or an undefined command is dropped. A query walks back
// hop by hop to the head, counts the chain forward member by member, then
// emits one result beat per member, because every step is one registered read
// of a link table whose data gives the next address. Each result carries the
// chain length, so the chain is counted before the first beat leaves. The walk
// back is bounded to CARS hops and the forward count to CARS members.
// Commands are taken only while no query is in progress.
module linked_chain_manager_unit #(
  parameter int unsigned CARS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcm_in_if.sink    in_i,
  lcm_out_if.source out_o
);
  import lcm_pkg::*;

  lcm_op_e   op;
  lcm_stat_t stat;

  lcm_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .op_o       (op)
  );

  lcm_datapath #(
    .CARS (CARS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (op),
    .in_cmd_i           (in_i.cmd),
    .in_item_a_i        (in_i.item_a),
    .in_item_b_i        (in_i.item_b),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_member_o       (out_o.member),
    .out_chain_length_o (out_o.chain_length),
    .out_last_o         (out_o.last),
    .stat_o             (stat)
  );

endmodule

[rtl/lcm_datapath.sv]
`timescale 1ns / 1ps
// Datapath: predecessor and successor link tables, walk registers, counters
// and the result register. Depends on lcm_pkg; driven by lcm_controller.
module lcm_datapath #(
  parameter int unsigned CARS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lcm_pkg::lcm_op_e                 op_i,
  input  logic [lcm_pkg::CMD_W-1:0]        in_cmd_i,
  input  logic [lcm_pkg::ITEM_W-1:0]       in_item_a_i,
  input  logic [lcm_pkg::ITEM_W-1:0]       in_item_b_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [lcm_pkg::ITEM_W-1:0]       out_member_o,
  output logic [lcm_pkg::ITEM_W-1:0]       out_chain_length_o,
  output logic                             out_last_o,
  output lcm_pkg::lcm_stat_t               stat_o
);
  import lcm_pkg::*;

  localparam int unsigned IDX_W = $clog2(CARS);
  localparam int unsigned CNT_W = $clog2(CARS + 1);

  function automatic logic [IDX_W-1:0] to_idx(input logic [ITEM_W-1:0] v);
    logic [ITEM_W-1:0] t;
    t = v - ITEM_W'(1);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic item_ok(input logic [ITEM_W-1:0] v);
    return (v != '0) && (v <= ITEM_W'(CARS));
  endfunction

  // Link tables
  logic [ITEM_W-1:0] pred_mem [CARS];
  logic [ITEM_W-1:0] succ_mem [CARS];
  logic [CARS-1:0]   pred_vld_q;
  logic [CARS-1:0]   succ_vld_q;

  logic [ITEM_W-1:0] pred_rdat_q, succ_rdat_q;
  logic              pred_rvld_q, succ_rvld_q;
  logic [ITEM_W-1:0] pred_rd, succ_rd;

  logic              pred_we, succ_we, pred_re, succ_re;
  logic [IDX_W-1:0]  pred_waddr, succ_waddr, pred_raddr, succ_raddr;
  logic [ITEM_W-1:0] pred_wdata, succ_wdata;

  // Walk state
  logic [ITEM_W-1:0] cur_q, cur_d;
  logic [ITEM_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  emit_q, emit_d;
  logic              use_rd_q, use_rd_d;
  logic [ITEM_W-1:0] cur_eff;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [ITEM_W-1:0] out_member_q, out_member_d;
  logic [ITEM_W-1:0] out_len_q, out_len_d;
  logic              out_last_q, out_last_d;
  logic              out_load;

  logic              a_ok, b_ok;

  assign pred_rd = pred_rvld_q ? pred_rdat_q : '0;
  assign succ_rd = succ_rvld_q ? succ_rdat_q : '0;
  assign cur_eff = use_rd_q ? succ_rd : cur_q;
  assign a_ok    = item_ok(in_item_a_i);
  assign b_ok    = item_ok(in_item_b_i);

  assign stat_o.query_go  = (in_cmd_i == CMD_QUERY) && a_ok;
  assign stat_o.back_more = (pred_rd != '0) && (steps_q < CNT_W'(CARS));
  assign stat_o.fwd_more  = (succ_rd != '0) && (cnt_q < CNT_W'(CARS));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.emit_last = ((emit_q + CNT_W'(1)) == cnt_q);

  assign out_load = (op_i == OP_EMIT) && stat_o.out_free;

  always_comb begin
    pred_we    = 1'b0;
    succ_we    = 1'b0;
    pred_re    = 1'b0;
    succ_re    = 1'b0;
    pred_waddr = to_idx(in_item_b_i);
    succ_waddr = to_idx(in_item_a_i);
    pred_wdata = '0;
    succ_wdata = '0;
    pred_raddr = to_idx(in_item_a_i);
    succ_raddr = to_idx(cur_q);
    cur_d      = cur_q;
    head_d     = head_q;
    steps_d    = steps_q;
    cnt_d      = cnt_q;
    emit_d     = emit_q;
    use_rd_d   = use_rd_q;

    unique case (op_i)
      OP_ACCEPT: begin
        case (in_cmd_i) inside
          CMD_LINK, CMD_UNLINK: begin
            pred_we    = a_ok && b_ok;
            succ_we    = a_ok && b_ok;
            pred_wdata = (in_cmd_i == CMD_LINK) ? in_item_a_i : '0;
            succ_wdata = (in_cmd_i == CMD_LINK) ? in_item_b_i : '0;
          end
          CMD_QUERY: begin
            pred_re = a_ok;
            cur_d   = in_item_a_i;
            steps_d = '0;
          end
          default: ;
        endcase
      end
      OP_BACK: begin
        if (stat_o.back_more) begin
          // hop to the predecessor and fetch its link
          pred_re    = 1'b1;
          pred_raddr = to_idx(pred_rd);
          cur_d      = pred_rd;
          steps_d    = steps_q + CNT_W'(1);
        end else begin
          // head found: start the forward count
          head_d     = cur_q;
          succ_re    = 1'b1;
          succ_raddr = to_idx(cur_q);
          cnt_d      = CNT_W'(1);
        end
      end
      OP_COUNT: begin
        if (stat_o.fwd_more) begin
          succ_re    = 1'b1;
          succ_raddr = to_idx(succ_rd);
          cnt_d      = cnt_q + CNT_W'(1);
        end else begin
          cur_d    = head_q;
          use_rd_d = 1'b0;
          emit_d   = '0;
        end
      end
      OP_EMIT: begin
        if (stat_o.out_free) begin
          succ_re    = 1'b1;
          succ_raddr = to_idx(cur_eff);
          use_rd_d   = 1'b1;
          emit_d     = emit_q + CNT_W'(1);
        end else begin
          // hold the walk position while the result beat stalls
          cur_d    = cur_eff;
          use_rd_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_member_d = out_member_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_member_d = cur_eff;
      out_len_d    = ITEM_W'(cnt_q);
      out_last_d   = stat_o.emit_last;
    end
  end

  // Table storage and registered reads
  always_ff @(posedge clk_i) begin
    if (pred_we) pred_mem[pred_waddr] <= pred_wdata;
    if (succ_we) succ_mem[succ_waddr] <= succ_wdata;
    if (pred_re) pred_rdat_q <= pred_mem[pred_raddr];
    if (succ_re) succ_rdat_q <= succ_mem[succ_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_vld_q  <= '0;
      succ_vld_q  <= '0;
      pred_rvld_q <= 1'b0;
      succ_rvld_q <= 1'b0;
      use_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pred_we) pred_vld_q[pred_waddr] <= 1'b1;
      if (succ_we) succ_vld_q[succ_waddr] <= 1'b1;
      if (pred_re) pred_rvld_q <= pred_vld_q[pred_raddr];
      if (succ_re) succ_rvld_q <= succ_vld_q[succ_raddr];
      use_rd_q    <= use_rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    head_q       <= head_d;
    steps_q      <= steps_d;
    cnt_q        <= cnt_d;
    emit_q       <= emit_d;
    out_member_q <= out_member_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_member_o       = out_member_q;
  assign out_chain_length_o = out_len_q;
  assign out_last_o         = out_last_q;

`ifndef SYNTHESIS
  a_member_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_member_q != '0) && (out_len_q != '0))
    else $error("result beat with empty member or length");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_EMIT) |-> (emit_q < cnt_q))
    else $error("emission ran past the counted chain length");

  a_back_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_BACK) |-> (steps_q <= CNT_W'(CARS)))
    else $error("predecessor walk exceeded its bound");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && stat_o.emit_last) |=> (op_i != OP_EMIT))
    else $error("emission continued after the tail beat");
`endif

endmodule

[rtl/lcm_controller.sv]
`timescale 1ns / 1ps
// Controller FSM: sequences accept, predecessor walk, forward count and
// emission. Depends on lcm_pkg; drives lcm_datapath through op_o.
module lcm_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lcm_pkg::lcm_stat_t stat_i,
  output lcm_pkg::lcm_op_e   op_o
);
  import lcm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BACK,
    ST_COUNT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_ACCEPT;
          if (stat_i.query_go) state_d = ST_BACK;
        end
      end
      ST_BACK: begin
        op_o = OP_BACK;
        if (!stat_i.back_more) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        op_o = OP_COUNT;
        if (!stat_i.fwd_more) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        op_o = OP_EMIT;
        if (stat_i.out_free && stat_i.emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
